// ===== hdl/assert_macros.svh =====
// Assertion helpers, sampled on clk and quiet while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

`define ASSERT_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

// ===== hdl/rgbgq_pkg.sv =====
`timescale 1ns / 1ps

package rgbgq_pkg;

  typedef logic [7:0] chan_t;
  typedef logic [1:0] level_t;

  localparam logic [31:0] HASH_MUL_X = 32'd374761393;
  localparam logic [31:0] HASH_MUL_Y = 32'd668265263;
  localparam logic [31:0] HASH_MUL_M = 32'd1274126177;

  localparam logic [7:0] LUMA_K_R = 8'd77;
  localparam logic [7:0] LUMA_K_G = 8'd150;
  localparam logic [7:0] LUMA_K_B = 8'd29;

  localparam logic [7:0] SPREAD_MIN = 8'd28;
  localparam logic [7:0] W_MAX      = 8'd180;
  localparam logic [7:0] W_BASE     = 8'd48;
  localparam logic [9:0] RECIP_3    = 10'd683;

  localparam logic [7:0] LVL_TH_1 = 8'd45;
  localparam logic [7:0] LVL_TH_2 = 8'd70;
  localparam logic [7:0] LVL_TH_3 = 8'd140;

  localparam level_t LEVEL_DARK  = 2'd0;
  localparam level_t LEVEL_MID_D = 2'd1;
  localparam level_t LEVEL_MID_B = 2'd2;
  localparam level_t LEVEL_BRIGHT = 2'd3;

  localparam logic [7:0] MID_GRAY  = 8'd128;
  localparam logic [7:0] LIFT_TH_0 = 8'd24;
  localparam logic [7:0] LIFT_TH_1 = 8'd96;
  localparam logic [7:0] LIFT_TH_2 = 8'd176;
  localparam logic [7:0] LIFT_TH_3 = 8'd232;
  localparam logic [7:0] LIFT_ADD_1 = 8'd18;
  localparam logic [7:0] LIFT_ADD_2 = 8'd24;
  localparam logic [7:0] LIFT_ADD_3 = 8'd14;
  localparam logic [7:0] LIFT_ADD_4 = 8'd4;

endpackage

// ===== hdl/rgbgq_ifs.sv =====
`timescale 1ns / 1ps

interface rgbgq_in_if #(parameter int COORD_BITS = 12);
  logic                    valid;
  logic                    ready;
  rgbgq_pkg::chan_t        red;
  rgbgq_pkg::chan_t        green;
  rgbgq_pkg::chan_t        blue;
  logic [COORD_BITS-1:0]   pos_x;
  logic [COORD_BITS-1:0]   pos_y;

  modport source (output valid, red, green, blue, pos_x, pos_y, input ready);
  modport sink   (input valid, red, green, blue, pos_x, pos_y, output ready);
endinterface

interface rgbgq_out_if;
  logic                    valid;
  logic                    ready;
  rgbgq_pkg::chan_t        gray;
  rgbgq_pkg::level_t       level_two_bit;
  logic                    bit_one;

  modport source (output valid, gray, level_two_bit, bit_one, input ready);
  modport sink   (input valid, gray, level_two_bit, bit_one, output ready);
endinterface

// ===== hdl/rgb_to_gray_tone_quantize.sv =====
// RGB pixel to gray, four-tone level and dithered one-bit value.
// in_pix  : valid/ready channel carrying red, green, blue and the pixel's
//           column/row (pos_x, pos_y, COORD_BITS wide each).
// out_pix : valid/ready channel carrying gray (chroma-lifted BT.601 luma),
//           level_two_bit (0 darkest .. 3 brightest) and bit_one
//           (hash-dithered monochrome, 1 = white).
// Five register stages: luma terms and coordinate products, luma sum and
// lift weight, lift product and final hash multiply, divide by 255 and
// clamp, then the quantizers into the output register.
// Throughput: one item per cycle while out_pix is not stalled; the two
// coordinate hash multiplies share stage 1, the final one has stage 3.
// Stall: when out_pix.ready is low with a result waiting, the whole pipe
// holds and in_pix.ready drops in the same cycle; nothing is lost or
// repeated. Bubbles advance whenever the output register is empty or taken.
// Reset (rst_n low, synchronous): all stage valid bits clear; the pipe is
// empty and ready on the first cycle after reset.
`timescale 1ns / 1ps

`include "assert_macros.svh"

module rgb_to_gray_tone_quantize #(
  parameter int COORD_BITS = 12
) (
  input logic       clk,
  input logic       rst_n,
  rgbgq_in_if.sink  in_pix,
  rgbgq_out_if.source out_pix
);
  import rgbgq_pkg::*;

  logic adv;
  logic [COORD_BITS-1:0] x_in, y_in;

  // stage 1
  logic        v1_r;
  chan_t       lr_r, lg_r, lb_r, hi1_r, lo1_r;
  logic [31:0] hx_r, hy_r;
  logic [15:0] mr, mg, mb;
  chan_t       hi_nxt, lo_nxt;

  // stage 2
  logic        v2_r;
  chan_t       luma2_r, hi2_r, w2_r;
  logic        big2_r;
  logic [31:0] h1_r;
  logic [8:0]  luma_sum;
  chan_t       spread;
  logic [8:0]  spread2;
  logic [18:0] q3_prod;
  logic [8:0]  w_raw;
  chan_t       w_nxt;

  // stage 3
  logic        v3_r;
  chan_t       luma3_r, t3_r;
  logic        big3_r;
  logic [15:0] prod3_r;
  chan_t       diff;
  logic [31:0] h1_mix, h2;

  // stage 4
  logic        v4_r;
  chan_t       gray4_r, t4_r;
  logic [16:0] q255_sum;
  chan_t       q255;
  logic [8:0]  lifted;
  chan_t       gray_nxt;

  // stage 5 / output
  logic        v5_r;
  chan_t       gray5_r;
  level_t      level5_r;
  logic        bit5_r;
  level_t      level_nxt;
  logic [8:0]  mono_sum;
  chan_t       mono;
  chan_t       limit;

  assign adv          = !v5_r || out_pix.ready;
  assign in_pix.ready = adv;
  assign x_in         = in_pix.pos_x;
  assign y_in         = in_pix.pos_y;

  // ---- stage 1 ----
  always_comb begin
    mr     = 16'(in_pix.red * LUMA_K_R);
    mg     = 16'(in_pix.green * LUMA_K_G);
    mb     = 16'(in_pix.blue * LUMA_K_B);
    hi_nxt = in_pix.red;
    lo_nxt = in_pix.red;
    if (in_pix.green > hi_nxt) hi_nxt = in_pix.green;
    if (in_pix.blue > hi_nxt)  hi_nxt = in_pix.blue;
    if (in_pix.green < lo_nxt) lo_nxt = in_pix.green;
    if (in_pix.blue < lo_nxt)  lo_nxt = in_pix.blue;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      lr_r  <= mr[15:8];
      lg_r  <= mg[15:8];
      lb_r  <= mb[15:8];
      hi1_r <= hi_nxt;
      lo1_r <= lo_nxt;
      hx_r  <= 32'(32'(x_in) * HASH_MUL_X);
      hy_r  <= 32'(32'(y_in) * HASH_MUL_Y);
    end
  end

  // ---- stage 2 ----
  always_comb begin
    luma_sum = 9'(lr_r) + 9'(lg_r) + 9'(lb_r);
    spread   = hi1_r - lo1_r;
    spread2  = {spread, 1'b0};
    q3_prod  = 19'(spread2 * RECIP_3);      // floor(v/3) for v < 768
    w_raw    = 9'(q3_prod[18:11]) + 9'(W_BASE);
    w_nxt    = (w_raw > 9'(W_MAX)) ? W_MAX : w_raw[7:0];
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      luma2_r <= luma_sum[7:0];
      hi2_r   <= hi1_r;
      w2_r    <= w_nxt;
      big2_r  <= (spread >= SPREAD_MIN);
      h1_r    <= hx_r + hy_r;
    end
  end

  // ---- stage 3 ----
  always_comb begin
    diff   = hi2_r - luma2_r;
    h1_mix = h1_r ^ (h1_r >> 13);
    h2     = 32'(h1_mix * HASH_MUL_M);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      luma3_r <= luma2_r;
      big3_r  <= big2_r;
      prod3_r <= 16'(diff * w2_r);
      t3_r    <= h2[31:24];
    end
  end

  // ---- stage 4 ----
  always_comb begin
    q255_sum = 17'(prod3_r) + 17'(prod3_r[15:8]) + 17'd1;  // floor(p/255)
    q255     = q255_sum[15:8];
    lifted   = 9'(luma3_r) + 9'(q255);
    if (!big3_r)          gray_nxt = luma3_r;
    else if (lifted[8])   gray_nxt = 8'hff;
    else                  gray_nxt = lifted[7:0];
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      gray4_r <= gray_nxt;
      t4_r    <= t3_r;
    end
  end

  // ---- stage 5 ----
  always_comb begin
    priority if (gray4_r < LVL_TH_1) level_nxt = LEVEL_DARK;
    else if (gray4_r < LVL_TH_2)     level_nxt = LEVEL_MID_D;
    else if (gray4_r < LVL_TH_3)     level_nxt = LEVEL_MID_B;
    else                             level_nxt = LEVEL_BRIGHT;

    priority if (gray4_r < LIFT_TH_0) mono_sum = 9'(gray4_r);
    else if (gray4_r < LIFT_TH_1)     mono_sum = 9'(gray4_r) + 9'(LIFT_ADD_1);
    else if (gray4_r < LIFT_TH_2)     mono_sum = 9'(gray4_r) + 9'(LIFT_ADD_2);
    else if (gray4_r < LIFT_TH_3)     mono_sum = 9'(gray4_r) + 9'(LIFT_ADD_3);
    else                              mono_sum = 9'(gray4_r) + 9'(LIFT_ADD_4);
    mono = mono_sum[8] ? 8'hff : mono_sum[7:0];

    // 128 + (t - 128) / 2, truncating toward zero
    if (t4_r >= MID_GRAY) limit = MID_GRAY + ((t4_r - MID_GRAY) >> 1);
    else                  limit = MID_GRAY - ((MID_GRAY - t4_r) >> 1);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      gray5_r  <= gray4_r;
      level5_r <= level_nxt;
      bit5_r   <= (mono >= limit);
    end
  end

  // ---- valid chain ----
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
    end else if (adv) begin
      v1_r <= in_pix.valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
      v5_r <= v4_r;
    end
  end

  assign out_pix.valid         = v5_r;
  assign out_pix.gray          = gray5_r;
  assign out_pix.level_two_bit = level5_r;
  assign out_pix.bit_one       = bit5_r;

  `ASSERT_CLK(a_ready_only_on_stall, !in_pix.ready |-> (out_pix.valid && !out_pix.ready), "input stalled without an output stall")
  `ASSERT_CLK(a_level_matches_gray, out_pix.valid |-> ((out_pix.level_two_bit == LEVEL_BRIGHT) == (out_pix.gray >= LVL_TH_3)), "level disagrees with gray")
  `ASSERT_NEVER(a_lift_below_luma, v4_r && (gray4_r < 8'($past(luma3_r))) && $past(adv), "lifted gray fell below luma")

endmodule
